### design/cumulative_frequency_lookup_defines.svh
// Assertion macros for the cumulative frequency lookup block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CUMULATIVE_FREQUENCY_LOOKUP_DEFINES_SVH
`define CUMULATIVE_FREQUENCY_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS

`define CFL_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define CFL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CFL_ASSERT(label, cond, msg)
`define CFL_ASSERT_IMPL(label, ante, cons, msg)
`define CFL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/cfl_pkg.sv
package cfl_pkg;

	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int COUNT_BITS_DEF  = 16;

	// Counts are stored four to a memory row.
	localparam int LANES     = 4;
	localparam int LANE_BITS = 2;

	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_INTERVAL = 2'd1;
	localparam logic [1:0] OP_FIND     = 2'd2;

	localparam logic [8:0]  ACTIVE_RESET = 9'd256;
	localparam logic [24:0] ACC_CAP      = 25'h100_0000;
	localparam logic [23:0] RANGE_MAX    = 24'hFF_FFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  symbol_index;
		logic [15:0] count_value;
		logic [23:0] target;
	} req_t;

	typedef struct packed {
		logic [23:0] range_low;
		logic [23:0] range_high;
		logic [7:0]  found_symbol;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic ready;
		logic clearing;
		logic done;
	} eng_stat_t;

	// Running sums are held capped at 2**24: anything at or above it saturates on output
	// and exceeds every target, so the cap changes no result.
	function automatic logic [24:0] cap_sum(input logic [32:0] s);
		logic [24:0] r;
		if (s > {8'd0, ACC_CAP}) begin
			r = ACC_CAP;
		end else begin
			r = s[24:0];
		end
		return r;
	endfunction

	function automatic logic [23:0] sat24(input logic [24:0] v);
		logic [23:0] r;
		if (v[24]) begin
			r = RANGE_MAX;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

### design/cfl_mem.sv
module cfl_mem #(
	parameter int ROWS  = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/cfl_engine.sv
module cfl_engine #(
	parameter int NUM_SYMBOLS = 256,
	parameter int COUNT_BITS  = 16,
	parameter int ROWS        = 64,
	parameter int AW          = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  cfl_pkg::req_t                      req,
	input  logic [8:0]                         active_symbols,
	input  logic                               take,
	output cfl_pkg::eng_stat_t                 stat,
	output cfl_pkg::rsp_t                      res,
	output logic                               mem_rd_en,
	output logic [AW-1:0]                      mem_rd_addr,
	input  logic [cfl_pkg::LANES*COUNT_BITS-1:0] mem_rd_data,
	output logic                               mem_wr_en,
	output logic [AW-1:0]                      mem_wr_addr,
	output logic [cfl_pkg::LANES*COUNT_BITS-1:0] mem_wr_data
);

	localparam int RW = cfl_pkg::LANES * COUNT_BITS;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WRMOD = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [1:0]            op_q;
	logic [7:0]            sym_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [23:0]           tgt_q;
	logic [8:0]            neff_q;
	logic [AW-1:0]         last_row_q;
	logic [24:0]           acc_q;
	logic [AW-1:0]         row_s1;
	cfl_pkg::rsp_t         res_q;

	// Decode of the incoming beat.
	logic          sym_in_table;
	logic [8:0]    n_eff;
	logic [AW-1:0] sym_row;
	logic [AW-1:0] find_last;
	logic [AW-1:0] int_last;

	assign sym_in_table = 16'(req.symbol_index) < 16'(NUM_SYMBOLS);
	assign n_eff = (16'(active_symbols) > 16'(NUM_SYMBOLS)) ? 9'(NUM_SYMBOLS)
		: active_symbols;
	assign sym_row   = AW'(16'(req.symbol_index) >> cfl_pkg::LANE_BITS);
	assign find_last = AW'((16'(n_eff) - 16'd1) >> cfl_pkg::LANE_BITS);
	assign int_last  = sym_in_table ? sym_row : AW'(ROWS - 1);

	// Four-lane accumulation over the row that the memory presents.
	logic [24:0]     run;
	logic [32:0]     own;
	logic            found;
	logic [24:0]     f_lo;
	logic [24:0]     f_hi;
	logic [7:0]      f_idx;
	logic [15:0]     lane_idx;
	logic [32:0]     lane_cnt;
	logic [24:0]     lane_hi;
	logic [24:0]     int_hi;
	logic [RW-1:0]   mod_row;

	always_comb begin
		run   = acc_q;
		own   = '0;
		found = 1'b0;
		f_lo  = '0;
		f_hi  = '0;
		f_idx = '0;
		lane_idx = '0;
		lane_cnt = '0;
		lane_hi  = '0;
		for (int l = 0; l < cfl_pkg::LANES; l++) begin
			lane_idx = 16'({row_s1, cfl_pkg::LANE_BITS'(l)});
			lane_cnt = 33'(mem_rd_data[l*COUNT_BITS +: COUNT_BITS]);
			lane_hi  = cfl_pkg::cap_sum(33'(run) + lane_cnt);
			if (op_q == cfl_pkg::OP_FIND) begin
				if (!found && lane_idx < 16'(neff_q)) begin
					if (lane_hi > {1'b0, tgt_q}) begin
						found = 1'b1;
						f_lo  = run;
						f_hi  = lane_hi;
						f_idx = lane_idx[7:0];
					end else begin
						run = lane_hi;
					end
				end
			end else begin
				if (lane_idx < 16'(sym_q)) begin
					run = lane_hi;
				end
				if (lane_idx == 16'(sym_q)) begin
					own = lane_cnt;
				end
			end
		end
		int_hi = cfl_pkg::cap_sum(33'(run) + own);
	end

	always_comb begin
		mod_row = mem_rd_data;
		for (int l = 0; l < cfl_pkg::LANES; l++) begin
			if (cfl_pkg::LANE_BITS'(l) == sym_q[cfl_pkg::LANE_BITS-1:0]) begin
				mod_row[l*COUNT_BITS +: COUNT_BITS] = cnt_q;
			end
		end
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
			end
			ST_IDLE: begin
				mem_rd_en   = req_valid;
				mem_rd_addr = (req.operation == cfl_pkg::OP_WRITE) ? sym_row : '0;
			end
			ST_WRMOD: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = row_s1;
				mem_wr_data = mod_row;
			end
			ST_WALK: begin
				// The next row is fetched while this one is summed.
				mem_rd_en   = 1'b1;
				mem_rd_addr = row_s1 + AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						case (req.operation)
							cfl_pkg::OP_WRITE: begin
								state_q <= sym_in_table ? ST_WRMOD : ST_DONE;
							end
							cfl_pkg::OP_INTERVAL: begin
								state_q <= ST_WALK;
							end
							cfl_pkg::OP_FIND: begin
								state_q <= (n_eff == 9'd0) ? ST_DONE : ST_WALK;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WRMOD: begin
					state_q <= ST_DONE;
				end
				ST_WALK: begin
					if ((op_q == cfl_pkg::OP_FIND && found) || row_s1 == last_row_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q   <= req.operation;
				sym_q  <= req.symbol_index;
				cnt_q  <= COUNT_BITS'(32'(req.count_value));
				tgt_q  <= req.target;
				neff_q <= n_eff;
				acc_q  <= '0;
				res_q.range_low    <= '0;
				res_q.range_high   <= '0;
				res_q.found_symbol <= '0;
				res_q.status       <= (req.operation == cfl_pkg::OP_FIND) && (n_eff == 9'd0);
				row_s1 <= (req.operation == cfl_pkg::OP_WRITE) ? sym_row : '0;
				last_row_q <= (req.operation == cfl_pkg::OP_FIND) ? find_last : int_last;
			end
			ST_WALK: begin
				acc_q  <= run;
				row_s1 <= row_s1 + AW'(1);
				if (op_q == cfl_pkg::OP_FIND) begin
					if (found) begin
						res_q.range_low    <= cfl_pkg::sat24(f_lo);
						res_q.range_high   <= cfl_pkg::sat24(f_hi);
						res_q.found_symbol <= f_idx;
						res_q.status       <= 1'b0;
					end else if (row_s1 == last_row_q) begin
						res_q.status <= 1'b1;
					end
				end else if (row_s1 == last_row_q) begin
					res_q.range_low  <= cfl_pkg::sat24(run);
					res_q.range_high <= cfl_pkg::sat24(int_hi);
				end
			end
			default: begin
			end
		endcase
	end

	assign res            = res_q;
	assign stat.ready     = (state_q == ST_IDLE);
	assign stat.clearing  = (state_q == ST_CLEAR);
	assign stat.done      = (state_q == ST_DONE);

endmodule

### design/cumulative_frequency_lookup.sv
// Cumulative frequency table for an arithmetic coder.
// Requests arrive on req (valid/ready) and carry an operation: write one count,
// ask the interval of a symbol, or find the symbol that covers a target.
// Each request yields exactly one beat on rsp (valid/ready).
// Counts sit in one memory, four to a row; a query streams one row per cycle
// through a four-lane adder chain: an interval reads the rows up to its symbol's row,
// and a find reads at most the rows that hold the first min(active_symbols, NUM_SYMBOLS)
// symbols and stops at the row that covers the target. A write is a
// read-modify-write of its row.
// One request is worked on at a time; req_ready rises again once the result has
// moved to the output register, so a new request may be taken while rsp waits.
// If the receiver stalls, the finished result waits in the engine and req_ready
// stays low until the output register frees.
// After reset the table is cleared one row per cycle, ceil(NUM_SYMBOLS/4)
// rows (64 by default), with req_ready low; cfg_wr_en writes active_symbols
// at any time and it resets to 256.
module cumulative_frequency_lookup #(
	parameter int NUM_SYMBOLS = cfl_pkg::NUM_SYMBOLS_DEF,
	parameter int COUNT_BITS  = cfl_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cfl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cfl_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic [8:0]    cfg_wr_data
);

`include "cumulative_frequency_lookup_defines.svh"

	localparam int ROWS = (NUM_SYMBOLS + cfl_pkg::LANES - 1) / cfl_pkg::LANES;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RW   = cfl_pkg::LANES * COUNT_BITS;

	logic [8:0]         active_q;
	logic               rsp_valid_q;
	cfl_pkg::rsp_t      rsp_q;
	cfl_pkg::eng_stat_t stat;
	cfl_pkg::rsp_t      res;
	logic               load;

	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [RW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [RW-1:0] mem_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= cfl_pkg::ACTIVE_RESET;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	cfl_engine #(
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.COUNT_BITS  (COUNT_BITS),
		.ROWS        (ROWS),
		.AW          (AW)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req            (req),
		.active_symbols (active_q),
		.take           (load),
		.stat           (stat),
		.res            (res),
		.mem_rd_en      (mem_rd_en),
		.mem_rd_addr    (mem_rd_addr),
		.mem_rd_data    (mem_rd_data),
		.mem_wr_en      (mem_wr_en),
		.mem_wr_addr    (mem_wr_addr),
		.mem_wr_data    (mem_wr_data)
	);

	cfl_mem #(
		.ROWS  (ROWS),
		.AW    (AW),
		.WIDTH (RW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// The finished result moves across whenever the output register is empty or being emptied.
	assign load = stat.done && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res;
		end
	end

	assign req_ready = stat.ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CFL_ASSERT_IMPL(a_no_req_while_clearing, stat.clearing, !req_ready, "ready during clear")
	`CFL_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second beat taken")
	`CFL_ASSERT_NEXT(a_result_held, stat.done && !load, stat.done, "result dropped while stalled")
	`CFL_ASSERT_IMPL(a_error_is_zero, rsp_valid && rsp.status,
		rsp.range_low == 24'd0 && rsp.range_high == 24'd0 && rsp.found_symbol == 8'd0,
		"error beat carries data")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cfl_pkg::*;

	localparam logic [1:0] OP_NONE  = 2'd3;
	localparam logic       ST_OK    = 1'b0;
	localparam logic       ST_RANGE = 1'b1;

	localparam int PLAN_LEN     = 30;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 135;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_AT_BEAT = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_TX_LO  = 300;
	localparam int QUIET_TX_HI  = 450;
	localparam int QUIET_RX_LO  = 600;
	localparam int QUIET_RX_HI  = 750;

	typedef struct packed {
		logic       is_cfg;
		logic [8:0] cfg_val;
		logic       typed;
		req_t       req;
		rsp_t       want;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_wr_en = 1'b0;
	logic [8:0] cfg_wr_data = '0;

	// Shadow copy of the count table and the search length.
	logic [15:0] freq_tab [NUM_SYMBOLS_DEF];
	logic [8:0]  active_cfg = ACTIVE_RESET;

	rsp_t due_answers [$];
	int   fail_count = 0;
	int   items_sent = 0;
	int   rsp_beats = 0;
	int   cycle_count = 0;
	logic long_hold_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cumulative_frequency_lookup u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	function automatic int unsigned span_len();
		return (active_cfg > ACTIVE_RESET) ? NUM_SYMBOLS_DEF : int'(active_cfg);
	endfunction

	function automatic logic [23:0] clip24(input int unsigned v);
		return (v > RANGE_MAX) ? RANGE_MAX : v[23:0];
	endfunction

	function automatic int unsigned active_total();
		int unsigned s;
		s = 0;
		for (int i = 0; i < span_len(); i++) begin
			s += freq_tab[i];
		end
		return s;
	endfunction

	function automatic rsp_t cum_lookup(input req_t r);
		rsp_t        o;
		int unsigned below;
		int unsigned upto;
		logic        hit;
		o = '0;
		below = 0;
		hit = 1'b0;
		case (r.operation)
			OP_WRITE: begin
				freq_tab[r.symbol_index] = r.count_value;
			end
			OP_INTERVAL: begin
				for (int i = 0; i < r.symbol_index; i++) begin
					below += freq_tab[i];
				end
				o.range_low  = clip24(below);
				o.range_high = clip24(below + freq_tab[r.symbol_index]);
			end
			OP_FIND: begin
				for (int i = 0; i < span_len(); i++) begin
					upto = below + freq_tab[i];
					if (!hit && upto > r.target) begin
						hit = 1'b1;
						o.range_low    = clip24(below);
						o.range_high   = clip24(upto);
						o.found_symbol = 8'(i);
					end
					below = upto;
				end
				if (!hit) begin
					o.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Finds mostly aim inside the current total so that the search lands on a symbol.
	function automatic req_t gen_item();
		req_t        r;
		int unsigned pick;
		int unsigned k;
		int unsigned tot;
		int unsigned span;
		r.symbol_index = 8'($urandom);
		r.count_value  = 16'($urandom);
		r.target       = 24'($urandom);
		span = span_len();
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		if (pick < 30) begin
			r.operation = OP_WRITE;
			if (span > 0 && span < NUM_SYMBOLS_DEF && k < 70) begin
				r.symbol_index = 8'($urandom_range(0, span - 1));
			end
			k = $urandom_range(0, 99);
			if (k < 45) begin
				r.count_value = 16'($urandom_range(0, 15));
			end else if (k < 75) begin
				r.count_value = 16'($urandom_range(0, 4095));
			end else if (k >= 95 && k < 97) begin
				r.count_value = '0;
			end else if (k >= 97) begin
				r.count_value = '1;
			end
		end else if (pick < 58) begin
			r.operation = OP_INTERVAL;
		end else if (pick < 95) begin
			r.operation = OP_FIND;
			tot = active_total();
			if (tot != 0) begin
				if (k < 75) begin
					r.target = 24'($urandom_range(0, tot - 1));
				end else if (k < 85) begin
					r.target = 24'(tot);
				end else if (k < 92) begin
					r.target = 24'(tot - 1);
				end
			end
		end else begin
			r.operation = OP_NONE;
		end
		return r;
	endfunction

	function automatic plan_row_t mk_req(input logic [1:0] op, input logic [7:0] sym,
			input logic [15:0] cnt, input logic [23:0] tgt);
		plan_row_t p;
		p = '0;
		p.req = '{op, sym, cnt, tgt};
		return p;
	endfunction

	function automatic plan_row_t mk_chk(input logic [1:0] op, input logic [7:0] sym,
			input logic [15:0] cnt, input logic [23:0] tgt, input logic [23:0] lo,
			input logic [23:0] hi, input logic [7:0] fs, input logic st);
		plan_row_t p;
		p = mk_req(op, sym, cnt, tgt);
		p.typed = 1'b1;
		p.want = '{lo, hi, fs, st};
		return p;
	endfunction

	function automatic plan_row_t mk_cfg(input logic [8:0] v);
		plan_row_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.cfg_val = v;
		return p;
	endfunction

	task automatic send_item(input req_t r, input logic typed, input rsp_t want);
		rsp_t p;
		@(negedge clk);
		if (!(items_sent >= QUIET_TX_LO && items_sent < QUIET_TX_HI)
				&& $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < 6);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		p = cum_lookup(r);
		due_answers.push_back(typed ? want : p);
		items_sent++;
	endtask

	// The block must be idle for a register write, so drain every result first.
	task automatic set_active(input logic [8:0] v);
		@(negedge clk);
		req_valid <= 1'b0;
		while (due_answers.size() != 0) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		active_cfg = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		plan_row_t  plan [PLAN_LEN];
		logic [8:0] phase_active [RAND_PHASES];
		plan = '{
			mk_chk(OP_INTERVAL, 8'd255, 16'd0, 24'd0, 24'd0, 24'd0, 8'd0, ST_OK),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd0, 24'd0, 24'd0, 8'd0, ST_RANGE),
			mk_chk(OP_WRITE, 8'd0, 16'hFFFF, 24'd0, 24'd0, 24'd0, 8'd0, ST_OK),
			mk_chk(OP_WRITE, 8'd255, 16'hFFFF, 24'hFF_FFFF, 24'd0, 24'd0, 8'd0, ST_OK),
			mk_chk(OP_WRITE, 8'd1, 16'd1, 24'd0, 24'd0, 24'd0, 8'd0, ST_OK),
			mk_chk(OP_INTERVAL, 8'd0, 16'd0, 24'd0, 24'd0, 24'd65535, 8'd0, ST_OK),
			mk_chk(OP_INTERVAL, 8'd255, 16'd0, 24'd0, 24'd65536, 24'd131071, 8'd0, ST_OK),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd0, 24'd0, 24'd65535, 8'd0, ST_OK),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd65535, 24'd65535, 24'd65536, 8'd1, ST_OK),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd65536, 24'd65536, 24'd131071, 8'd255, ST_OK),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd131071, 24'd0, 24'd0, 8'd0, ST_RANGE),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'hFF_FFFF, 24'd0, 24'd0, 8'd0, ST_RANGE),
			mk_chk(OP_NONE, 8'd255, 16'hFFFF, 24'hFF_FFFF, 24'd0, 24'd0, 8'd0, ST_OK),
			mk_req(OP_INTERVAL, 8'd128, 16'd0, 24'd0),
			mk_req(OP_WRITE, 8'd128, 16'h5555, 24'd0),
			mk_req(OP_WRITE, 8'd200, 16'hAAAA, 24'd0),
			mk_req(OP_INTERVAL, 8'd200, 16'd0, 24'd0),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'h00_AAAA),
			mk_req(OP_WRITE, 8'd0, 16'd0, 24'd0),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'd0),
			mk_cfg(9'd2),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'd0),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'd1),
			mk_cfg(9'd1),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'd0),
			mk_cfg(9'd0),
			mk_chk(OP_FIND, 8'd0, 16'd0, 24'd0, 24'd0, 24'd0, 8'd0, ST_RANGE),
			mk_cfg(9'h1FF),
			mk_req(OP_FIND, 8'd0, 16'd0, 24'h01_5555),
			mk_req(OP_INTERVAL, 8'd254, 16'd0, 24'd0)
		};
		foreach (freq_tab[i]) begin
			freq_tab[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_active(plan[i].cfg_val);
			end else begin
				send_item(plan[i].req, plan[i].typed, plan[i].want);
			end
		end

		phase_active = '{ACTIVE_RESET, 9'd1, 9'd2, 9'($urandom_range(3, 255)), 9'h1FF,
			9'($urandom_range(257, 510)), 9'd64, ACTIVE_RESET};
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_active(phase_active[ph]);
			repeat (PHASE_ITEMS) send_item(gen_item(), 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (due_answers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_answers.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// One long hold-off fills the block and backs up the request side.
	initial begin
		forever begin
			@(negedge clk);
			if (!long_hold_done && rsp_beats >= HOLD_AT_BEAT) begin
				long_hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= (rsp_beats >= QUIET_RX_LO && rsp_beats < QUIET_RX_HI)
				|| ($urandom_range(0, 99) >= 6);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_beats++;
			if (due_answers.size() == 0) begin
				$error("result beat with no request outstanding: low %0d high %0d",
					rsp.range_low, rsp.range_high);
				fail_count++;
			end else begin
				want = due_answers.pop_front();
				if (rsp.range_low !== want.range_low) begin
					$error("range_low: expected %0d, got %0d", want.range_low, rsp.range_low);
					fail_count++;
				end
				if (rsp.range_high !== want.range_high) begin
					$error("range_high: expected %0d, got %0d", want.range_high,
						rsp.range_high);
					fail_count++;
				end
				if (rsp.found_symbol !== want.found_symbol) begin
					$error("found_symbol: expected %0d, got %0d", want.found_symbol,
						rsp.found_symbol);
					fail_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

### files.f
+incdir+design
design/cfl_pkg.sv
design/cfl_mem.sv
design/cfl_engine.sv
design/cumulative_frequency_lookup.sv
bench/tb_top.sv
